### rtl/upn_pkg.sv
// Package for the URL path normalizer: state and result types, byte and status codes,
// and the byte classification and UTF-8 checker functions.
// No dependencies.
`default_nettype none

package upn_pkg;

    // Hard ceiling on the path length limit
    localparam int MAX_PATH_LIMIT = 255;

    // Result queue geometry: one item yields at most three results
    localparam int MAX_RESULTS = 3;
    localparam int RES_DEPTH   = 4;
    localparam int RES_PTR_W   = $clog2(RES_DEPTH);
    localparam int RES_CNT_W   = $clog2(RES_DEPTH + 1);

    // Configuration register indexes
    localparam logic CFG_MAX_PATH_BYTES = 1'b0;
    localparam logic CFG_PCT_DECODE     = 1'b1;

    // Status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_BAD_ESCAPE  = 3'd1;
    localparam logic [2:0] ST_FORBIDDEN   = 3'd2;
    localparam logic [2:0] ST_TOO_LONG    = 3'd3;
    localparam logic [2:0] ST_EMPTY       = 3'd4;
    localparam logic [2:0] ST_BAD_CHARSET = 3'd5;

    // Escape decoder phases
    localparam logic [1:0] ESC_IDLE = 2'd0;
    localparam logic [1:0] ESC_HIGH = 2'd1;
    localparam logic [1:0] ESC_LOW  = 2'd2;

    // UTF-8 checker states
    localparam logic [3:0] U8_LEAD = 4'd0;
    localparam logic [3:0] U8_OWE1 = 4'd1;
    localparam logic [3:0] U8_OWE2 = 4'd2;
    localparam logic [3:0] U8_OWE3 = 4'd3;
    localparam logic [3:0] U8_E0   = 4'd4;
    localparam logic [3:0] U8_ED   = 4'd5;
    localparam logic [3:0] U8_F0   = 4'd6;
    localparam logic [3:0] U8_F4   = 4'd7;
    localparam logic [3:0] U8_BAD  = 4'd8;

    // Byte codes
    localparam logic [7:0] CH_SLASH   = 8'h2f;
    localparam logic [7:0] CH_DOT     = 8'h2e;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CTRL_LIMIT = 8'h20;
    localparam logic [7:0] DEL_BYTE   = 8'h7f;

    // Per-path scan state
    typedef struct packed {
        logic [1:0] esc_phase;
        logic [3:0] esc_hi;
        logic [8:0] seg_cnt;
        logic [8:0] out_cnt;
        logic       held_dot;
        logic       last_ds;
        logic [2:0] first_err;
        logic [3:0] utf8;
    } upn_state_t;

    // One result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_status;
        logic [2:0] status;
    } upn_result_t;

    // Results produced by one input item, compacted from slot 0
    typedef struct packed {
        logic [1:0]                         count;
        upn_result_t [MAX_RESULTS-1:0]      item;
    } upn_batch_t;

    function automatic logic hex_valid(input logic [7:0] c);
        hex_valid = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
                    (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        if (c <= 8'h39)
            d = c - 8'h30;
        else if (c >= 8'h61)
            d = c - 8'h57;
        else
            d = c - 8'h37;
        hex_value = d[3:0];
    endfunction

    function automatic logic byte_allowed(input logic [7:0] c);
        logic ok;
        ok = !(c < CTRL_LIMIT || c == DEL_BYTE);
        case (c)
            8'h5c, 8'h2f, 8'h3a, 8'h2a, 8'h3f, 8'h22, 8'h3c, 8'h3e, 8'h7c, 8'h23:
                ok = 1'b0;
            default: ;
        endcase
        byte_allowed = ok;
    endfunction

    // Strict UTF-8 checker step
    function automatic logic [3:0] utf8_next(input logic [3:0] s, input logic [7:0] c);
        logic       cont;
        logic [3:0] r;
        cont = (c[7:6] == 2'b10);
        r    = U8_BAD;
        unique case (s)
            U8_LEAD:
            begin
                if (c < 8'h80)                     r = U8_LEAD;
                else if (c >= 8'hc2 && c <= 8'hdf) r = U8_OWE1;
                else if (c == 8'he0)               r = U8_E0;
                else if (c == 8'hed)               r = U8_ED;
                else if (c >= 8'he1 && c <= 8'hef) r = U8_OWE2;
                else if (c == 8'hf0)               r = U8_F0;
                else if (c >= 8'hf1 && c <= 8'hf3) r = U8_OWE3;
                else if (c == 8'hf4)               r = U8_F4;
                else                               r = U8_BAD;
            end
            U8_OWE1: r = cont ? U8_LEAD : U8_BAD;
            U8_OWE2: r = cont ? U8_OWE1 : U8_BAD;
            U8_OWE3: r = cont ? U8_OWE2 : U8_BAD;
            U8_E0:   r = (c >= 8'ha0 && c <= 8'hbf) ? U8_OWE1 : U8_BAD;
            U8_ED:   r = (c >= 8'h80 && c <= 8'h9f) ? U8_OWE1 : U8_BAD;
            U8_F0:   r = (c >= 8'h90 && c <= 8'hbf) ? U8_OWE2 : U8_BAD;
            U8_F4:   r = (c >= 8'h80 && c <= 8'h8f) ? U8_OWE2 : U8_BAD;
            default: r = U8_BAD;
        endcase
        utf8_next = r;
    endfunction

endpackage

`default_nettype wire

### rtl/upn_step.sv
// Scan logic for one path item: next scan state and the results it causes.
// Depends on upn_pkg.
`default_nettype none

module upn_step
    import upn_pkg::*;
(
    input  upn_state_t  st,
    input  logic [7:0]  path_byte,
    input  logic        path_end,
    input  logic [7:0]  max_path_bytes,
    input  logic        pct_decode,
    output upn_state_t  st_next,
    output upn_batch_t  batch
);

    upn_state_t ns;
    logic [8:0] limit;
    logic [7:0] v;
    logic       do_take;
    logic       do_end;
    logic [1:0] n;

    always_comb
    begin
        ns      = st;
        n       = '0;
        batch   = '0;
        v       = '0;
        do_take = 1'b0;
        do_end  = 1'b0;
        limit   = (9'(max_path_bytes) < 9'(MAX_PATH_LIMIT)) ?
                  9'(max_path_bytes) : 9'(MAX_PATH_LIMIT);

        // classify the item
        if (path_end)
        begin
            if (st.first_err == ST_OK)
            begin
                if (st.esc_phase != ESC_IDLE)
                    ns.first_err = ST_BAD_ESCAPE;
                else
                    do_end = 1'b1;
            end
        end
        else if (st.first_err == ST_OK)
        begin
            if (st.esc_phase == ESC_HIGH)
            begin
                if (!hex_valid(path_byte))
                    ns.first_err = ST_BAD_ESCAPE;
                else
                begin
                    ns.esc_hi    = hex_value(path_byte);
                    ns.esc_phase = ESC_LOW;
                end
            end
            else if (st.esc_phase == ESC_LOW)
            begin
                if (!hex_valid(path_byte))
                    ns.first_err = ST_BAD_ESCAPE;
                else
                begin
                    ns.esc_phase = ESC_IDLE;
                    v            = {st.esc_hi, hex_value(path_byte)};
                    do_take      = 1'b1;
                end
            end
            else if (pct_decode && path_byte == CH_PERCENT)
                ns.esc_phase = ESC_HIGH;
            else if (path_byte == CH_SLASH)
                do_end = 1'b1;
            else
            begin
                v       = path_byte;
                do_take = 1'b1;
            end
        end

        // segment close: trailing dot/space check, then total length
        if (do_end)
        begin
            if (ns.seg_cnt != '0 && ns.first_err == ST_OK)
            begin
                if (ns.held_dot && ns.seg_cnt == 9'd1)
                    ;
                else if (ns.last_ds)
                    ns.first_err = ST_FORBIDDEN;
                else if (ns.out_cnt > limit)
                    ns.first_err = ST_TOO_LONG;
            end
            ns.seg_cnt  = '0;
            ns.held_dot = 1'b0;
            ns.last_ds  = 1'b0;
        end

        // terminator: final status, then clear for the next path
        if (path_end)
        begin
            if (ns.first_err == ST_OK)
            begin
                if (ns.out_cnt == '0)
                    ns.first_err = ST_EMPTY;
                else if (ns.utf8 != U8_LEAD)
                    ns.first_err = ST_BAD_CHARSET;
            end
            batch.item[0] = '{out_byte: 8'h00, is_status: 1'b1, status: ns.first_err};
            n  = 2'd1;
            ns = '0;
        end

        // keep one byte value
        if (do_take)
        begin
            if (!byte_allowed(v))
                ns.first_err = ST_FORBIDDEN;
            else if (ns.seg_cnt >= limit)
                ns.first_err = ST_TOO_LONG;
            else if (ns.seg_cnt == '0 && v == CH_DOT)
            begin
                ns.held_dot = 1'b1;
                ns.seg_cnt  = 9'd1;
                ns.last_ds  = 1'b1;
            end
            else
            begin
                if (ns.seg_cnt == '0 || ns.held_dot)
                begin
                    // separator before a new segment
                    if (ns.out_cnt != '0)
                    begin
                        batch.item[n] = '{out_byte: CH_SLASH, is_status: 1'b0,
                                          status: ST_OK};
                        n          = n + 2'd1;
                        ns.out_cnt = ns.out_cnt + 9'd1;
                        ns.utf8    = utf8_next(ns.utf8, CH_SLASH);
                    end
                    // release the held leading dot
                    if (ns.held_dot)
                    begin
                        batch.item[n] = '{out_byte: CH_DOT, is_status: 1'b0,
                                          status: ST_OK};
                        n           = n + 2'd1;
                        ns.out_cnt  = ns.out_cnt + 9'd1;
                        ns.utf8     = utf8_next(ns.utf8, CH_DOT);
                        ns.held_dot = 1'b0;
                    end
                end
                batch.item[n] = '{out_byte: v, is_status: 1'b0, status: ST_OK};
                n          = n + 2'd1;
                ns.out_cnt = ns.out_cnt + 9'd1;
                ns.utf8    = utf8_next(ns.utf8, v);
                ns.seg_cnt = ns.seg_cnt + 9'd1;
                ns.last_ds = (v == CH_DOT || v == CH_SPACE);
            end
        end

        batch.count = n;
        st_next     = ns;
    end

endmodule

`default_nettype wire

### rtl/upn_res_fifo.sv
// Result queue: takes up to three results per cycle, hands out one per transfer.
// Depends on upn_pkg.
`default_nettype none

module upn_res_fifo
    import upn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  upn_batch_t  batch,
    output logic        room,
    output logic        res_valid,
    input  logic        res_ready,
    output upn_result_t head
);

    upn_result_t          mem [RES_DEPTH];
    logic [RES_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [RES_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [RES_CNT_W-1:0] count_reg, count_next;
    logic [RES_CNT_W-1:0] push_cnt;
    logic                 pop;

    assign pop       = res_valid && res_ready;
    assign res_valid = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];
    // space for a worst-case batch
    assign room      = (count_reg <= RES_CNT_W'(RES_DEPTH - MAX_RESULTS));
    assign push_cnt  = push ? RES_CNT_W'(batch.count) : '0;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + RES_PTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + RES_PTR_W'(pop);
        count_next  = count_reg + push_cnt - RES_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage write, one slot per produced result
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            if (push && 2'(i) < batch.count)
                mem[wr_ptr_reg + RES_PTR_W'(i)] <= batch.item[i];
        end
    end

endmodule

`default_nettype wire

### rtl/url_path_normalizer.sv
// URL path normalizer, top level.
// Results are registered in the result queue. Throughput: one item per cycle while
// each item yields at most one result and res_ready stays high; an item that opens a
// segment yields up to three, drained one per cycle. The four-entry result queue
// takes an item only while at most one entry is occupied, which sets that figure.
// Reset clears config to defaults and all scan state; no clearing pass.
`default_nettype none

module url_path_normalizer
    import upn_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // path items
    input  logic       path_valid,
    output logic       path_ready,
    input  logic [7:0] path_byte,
    input  logic       path_end,
    // results
    output logic       res_valid,
    input  logic       res_ready,
    output logic [7:0] out_byte,
    output logic       is_status,
    output logic [2:0] status,
    output logic       last,
    // configuration
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data
);

    logic [7:0]  max_path_bytes_reg;
    logic        pct_decode_reg;
    upn_state_t  state_reg, state_next;
    upn_batch_t  batch;
    upn_result_t head;
    logic        accept;
    logic        room;

    assign accept     = path_valid && path_ready;
    assign path_ready = room;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_path_bytes_reg <= 8'd255;
            pct_decode_reg     <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAX_PATH_BYTES: max_path_bytes_reg <= cfg_data;
                CFG_PCT_DECODE:     pct_decode_reg     <= cfg_data[0];
            endcase
        end
    end

    upn_step u_step (
        .st             (state_reg),
        .path_byte      (path_byte),
        .path_end       (path_end),
        .max_path_bytes (max_path_bytes_reg),
        .pct_decode     (pct_decode_reg),
        .st_next        (state_next),
        .batch          (batch)
    );

    // scan state advances on each transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (accept)
            state_reg <= state_next;
    end

    upn_res_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .batch     (batch),
        .room      (room),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .head      (head)
    );

    assign out_byte  = head.out_byte;
    assign is_status = head.is_status;
    assign status    = head.status;
    assign last      = head.is_status;

endmodule

`default_nettype wire

### rtl/upn_checker.sv
// Port-level checks for the URL path normalizer, bound to the top level.
// Depends on upn_pkg and url_path_normalizer.
`default_nettype none

module upn_checker
    import upn_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input logic [7:0] out_byte,
    input logic       is_status,
    input logic [2:0] status,
    input logic       last
);

    // a stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(out_byte) &&
        $stable(is_status) && $stable(status) && $stable(last))
        else $error("result changed while stalled");

    // only the status item closes a path, and it carries no byte
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (is_status == last) && (!is_status || out_byte == 8'h00))
        else $error("status item framing wrong");

    // byte items carry no error code
    a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !is_status |-> status == ST_OK)
        else $error("byte item with nonzero status");

    // status code stays in range
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && is_status |-> status <= ST_BAD_CHARSET)
        else $error("status code out of range");

endmodule

bind url_path_normalizer upn_checker u_chk (.*);

`default_nettype wire

### test/tb_url_path_normalizer.sv
// Self-checking testbench for url_path_normalizer: directed and random request paths
// under several limit and decode settings, results predicted in-bench and compared.
// Depends on rtl/upn_pkg.sv and rtl/url_path_normalizer.sv.
`timescale 1ns / 100ps

module tb_url_path_normalizer
    import upn_pkg::*;
();

    localparam int WATCHDOG_CYCLES = 1000;

    typedef struct {
        bit [7:0] b;
        bit       e;
    } path_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_status;
        logic [2:0] status;
        logic       last;
    } norm_result_t;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       path_valid = 1'b0;
    logic       path_ready;
    logic [7:0] path_byte  = 8'h00;
    logic       path_end   = 1'b0;
    logic       res_valid;
    logic       res_ready  = 1'b0;
    logic [7:0] out_byte;
    logic       is_status;
    logic [2:0] status;
    logic       last;
    logic       cfg_we     = 1'b0;
    logic       cfg_index  = CFG_MAX_PATH_BYTES;
    logic [7:0] cfg_data   = 8'h00;

    url_path_normalizer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .path_valid (path_valid),
        .path_ready (path_ready),
        .path_byte  (path_byte),
        .path_end   (path_end),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .out_byte   (out_byte),
        .is_status  (is_status),
        .status     (status),
        .last       (last),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // Stimulus and expectation stores
    path_item_t   pending_path[$];
    norm_result_t expected_out[$];

    int unsigned error_count    = 0;
    int unsigned results_seen   = 0;
    int unsigned paths_done     = 0;
    int unsigned items_queued   = 0;
    int unsigned settings_used  = 1;
    int unsigned idle_cycles    = 0;
    int unsigned tx_gap         = 0;
    int unsigned rx_stall       = 0;
    int unsigned rx_hold_req    = 0;
    bit          quiet          = 1'b0;
    bit          path_xfer      = 1'b0;

    // Predictor copy of the configuration and the per-path scan state
    bit [7:0]    lim_reg     = 8'd255;
    bit          dec_en      = 1'b1;
    bit [1:0]    esc_st      = ESC_IDLE;
    bit [3:0]    esc_hi_n    = 4'h0;
    int unsigned seg_len     = 0;
    int unsigned out_len     = 0;
    bit          dot_held    = 1'b0;
    bit          tail_dot_sp = 1'b0;
    bit [2:0]    err_code    = ST_OK;
    bit [3:0]    u8_st       = U8_LEAD;

    initial
    begin
        forever #5 clk = ~clk;
    end

    //------------------------------------------------------------------
    // Predictor
    //------------------------------------------------------------------

    function automatic int hex_val(input bit [7:0] c);
        if (c >= "0" && c <= "9")
            return int'(c - "0");
        if (c >= "a" && c <= "f")
            return int'(c - "a") + 10;
        if (c >= "A" && c <= "F")
            return int'(c - "A") + 10;
        return -1;
    endfunction

    // Bytes a path component may carry
    function automatic bit path_char_ok(input bit [7:0] c);
        if (c < CTRL_LIMIT || c == DEL_BYTE)
            return 1'b0;
        if (c == CH_SLASH || c == "\\" || c == ":" || c == "*" || c == "?" ||
            c == "\"" || c == "<" || c == ">" || c == "|" || c == "#")
            return 1'b0;
        return 1'b1;
    endfunction

    function automatic int unsigned eff_limit();
        return (lim_reg < MAX_PATH_LIMIT) ? lim_reg : MAX_PATH_LIMIT;
    endfunction

    // Strict UTF-8 acceptor, one byte at a time
    function automatic bit [3:0] u8_step(input bit [3:0] s, input bit [7:0] c);
        bit cont;
        cont = (c[7:6] == 2'b10);
        case (s)
            U8_LEAD:
            begin
                if (c[7] == 1'b0)
                    return U8_LEAD;
                if (c >= 8'hc2 && c <= 8'hdf)
                    return U8_OWE1;
                if (c == 8'he0)
                    return U8_E0;
                if (c == 8'hed)
                    return U8_ED;
                if (c >= 8'he1 && c <= 8'hef)
                    return U8_OWE2;
                if (c == 8'hf0)
                    return U8_F0;
                if (c >= 8'hf1 && c <= 8'hf3)
                    return U8_OWE3;
                if (c == 8'hf4)
                    return U8_F4;
                return U8_BAD;
            end
            U8_OWE1, U8_OWE2, U8_OWE3:
                return cont ? s - 4'd1 : U8_BAD;
            U8_E0:
                return (c >= 8'ha0 && c <= 8'hbf) ? U8_OWE1 : U8_BAD;
            U8_ED:
                return (c >= 8'h80 && c <= 8'h9f) ? U8_OWE1 : U8_BAD;
            U8_F0:
                return (c >= 8'h90 && c <= 8'hbf) ? U8_OWE2 : U8_BAD;
            U8_F4:
                return (c >= 8'h80 && c <= 8'h8f) ? U8_OWE2 : U8_BAD;
            default:
                return U8_BAD;
        endcase
    endfunction

    task automatic put_byte(input bit [7:0] c);
        expected_out.push_back({c, 1'b0, ST_OK, 1'b0});
        if (out_len < 32'hffff)
            out_len++;
        u8_st = u8_step(u8_st, c);
    endtask

    // Segment boundary: dot-or-space rule first, then the total length
    task automatic close_seg();
        if (seg_len != 0 && err_code == ST_OK)
        begin
            if (!(dot_held && seg_len == 1))
            begin
                if (tail_dot_sp)
                    err_code = ST_FORBIDDEN;
                else if (out_len > eff_limit())
                    err_code = ST_TOO_LONG;
            end
        end
        seg_len     = 0;
        dot_held    = 1'b0;
        tail_dot_sp = 1'b0;
    endtask

    // A decoded or raw byte that belongs to a segment
    task automatic keep_value(input bit [7:0] v);
        if (!path_char_ok(v))
        begin
            err_code = ST_FORBIDDEN;
            return;
        end
        if (seg_len >= eff_limit())
        begin
            err_code = ST_TOO_LONG;
            return;
        end
        // leading dot waits until the segment proves not to be "."
        if (seg_len == 0 && v == CH_DOT)
        begin
            dot_held    = 1'b1;
            seg_len     = 1;
            tail_dot_sp = 1'b1;
            return;
        end
        if (seg_len == 0 || dot_held)
        begin
            if (out_len != 0)
                put_byte(CH_SLASH);
            if (dot_held)
            begin
                put_byte(CH_DOT);
                dot_held = 1'b0;
            end
        end
        put_byte(v);
        seg_len++;
        tail_dot_sp = (v == CH_DOT || v == CH_SPACE);
    endtask

    task automatic normalize_item(input bit [7:0] b, input bit term);
        int hv;
        if (term)
        begin
            if (err_code == ST_OK)
            begin
                if (esc_st != ESC_IDLE)
                    err_code = ST_BAD_ESCAPE;
                else
                    close_seg();
            end
            if (err_code == ST_OK)
            begin
                if (out_len == 0)
                    err_code = ST_EMPTY;
                else if (u8_st != U8_LEAD)
                    err_code = ST_BAD_CHARSET;
            end
            expected_out.push_back({8'h00, 1'b1, err_code, 1'b1});
            paths_done++;
            esc_st      = ESC_IDLE;
            esc_hi_n    = 4'h0;
            seg_len     = 0;
            out_len     = 0;
            dot_held    = 1'b0;
            tail_dot_sp = 1'b0;
            err_code    = ST_OK;
            u8_st       = U8_LEAD;
            return;
        end
        // after an error the rest of the path is swallowed
        if (err_code != ST_OK)
            return;
        case (esc_st)
            ESC_HIGH:
            begin
                hv = hex_val(b);
                if (hv < 0)
                    err_code = ST_BAD_ESCAPE;
                else
                begin
                    esc_hi_n = hv[3:0];
                    esc_st   = ESC_LOW;
                end
            end
            ESC_LOW:
            begin
                hv = hex_val(b);
                if (hv < 0)
                    err_code = ST_BAD_ESCAPE;
                else
                begin
                    esc_st = ESC_IDLE;
                    keep_value({esc_hi_n, hv[3:0]});
                end
            end
            default:
            begin
                if (dec_en && b == CH_PERCENT)
                    esc_st = ESC_HIGH;
                else if (b == CH_SLASH)
                    close_seg();
                else
                    keep_value(b);
            end
        endcase
    endtask

    //------------------------------------------------------------------
    // Stimulus helpers
    //------------------------------------------------------------------

    task automatic add_byte(input bit [7:0] b);
        pending_path.push_back('{b: b, e: 1'b0});
        items_queued++;
    endtask

    // Terminator with a random (ignored) byte
    task automatic add_end();
        pending_path.push_back('{b: 8'($urandom_range(0, 255)), e: 1'b1});
        items_queued++;
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endtask

    function automatic bit [7:0] hex_char(input bit [3:0] n, input bit upper);
        if (n < 10)
            return "0" + 8'(n);
        return (upper ? "A" : "a") + 8'(n) - 8'd10;
    endfunction

    task automatic add_escape(input bit [7:0] v);
        add_byte(CH_PERCENT);
        add_byte(hex_char(v[7:4], 1'($urandom_range(0, 1))));
        add_byte(hex_char(v[3:0], 1'($urandom_range(0, 1))));
    endtask

    // Segment content byte, sometimes percent-escaped
    task automatic add_value(input bit [7:0] v, input bit dec);
        if (dec && $urandom_range(0, 4) == 0)
            add_escape(v);
        else
            add_byte(v);
    endtask

    function automatic bit [7:0] plain_char();
        bit [7:0] c;
        do
            c = 8'($urandom_range(8'h21, 8'h7e));
        while (!path_char_ok(c) || c == CH_PERCENT);
        return c;
    endfunction

    // One UTF-8 sequence, mostly well formed
    task automatic add_utf8(input bit dec);
        bit [7:0] seq[$];
        case ($urandom_range(0, 7))
            0: seq = '{8'($urandom_range(8'hc2, 8'hdf)), 8'($urandom_range(8'h80, 8'hbf))};
            1: seq = '{8'he0, 8'($urandom_range(8'ha0, 8'hbf)), 8'($urandom_range(8'h80, 8'hbf))};
            2: seq = '{8'hed, 8'($urandom_range(8'h80, 8'h9f)), 8'($urandom_range(8'h80, 8'hbf))};
            3: seq = '{8'($urandom_range(8'he1, 8'hef)), 8'($urandom_range(8'h80, 8'hbf)),
                       8'($urandom_range(8'h80, 8'hbf))};
            4: seq = '{8'hf0, 8'($urandom_range(8'h90, 8'hbf)), 8'($urandom_range(8'h80, 8'hbf)),
                       8'($urandom_range(8'h80, 8'hbf))};
            5: seq = '{8'($urandom_range(8'hf1, 8'hf3)), 8'($urandom_range(8'h80, 8'hbf)),
                       8'($urandom_range(8'h80, 8'hbf)), 8'($urandom_range(8'h80, 8'hbf))};
            6: seq = '{8'hf4, 8'($urandom_range(8'h80, 8'h8f)), 8'($urandom_range(8'h80, 8'hbf)),
                       8'($urandom_range(8'h80, 8'hbf))};
            default: seq = '{8'($urandom_range(8'h80, 8'hff)), 8'($urandom_range(0, 255))};
        endcase
        foreach (seq[i])
            add_value(seq[i], dec);
    endtask

    // A random request path: mostly plausible segments, some noise and broken escapes
    task automatic add_random_path(input int unsigned lim, input bit dec);
        int unsigned nseg;
        int unsigned kind;
        int unsigned len;
        int unsigned s;
        nseg = $urandom_range(0, 4);
        if ($urandom_range(0, 2) == 0)
            add_byte(CH_SLASH);
        for (s = 0; s < nseg; s++)
        begin
            if (s != 0)
            begin
                add_byte(CH_SLASH);
                if ($urandom_range(0, 7) == 0)
                    add_byte(CH_SLASH);
            end
            kind = $urandom_range(0, 99);
            if (kind < 45)
            begin
                len = $urandom_range(1, 5);
                repeat (len)
                begin
                    if ($urandom_range(0, 5) == 0)
                        add_utf8(dec);
                    else
                        add_value(plain_char(), dec);
                end
            end
            else if (kind < 55)
                add_byte(CH_DOT);
            else if (kind < 62)
            begin
                add_byte(CH_DOT);
                repeat ($urandom_range(1, 3))
                    add_value(plain_char(), dec);
            end
            else if (kind < 70)
            begin
                repeat ($urandom_range(0, 3))
                    add_value(plain_char(), dec);
                add_value($urandom_range(0, 1) ? CH_DOT : CH_SPACE, dec);
            end
            else if (kind < 78)
            begin
                // around the segment limit when it is small
                if (lim <= 16)
                    len = $urandom_range((lim > 1) ? lim - 1 : 1, lim + 1);
                else
                    len = $urandom_range(6, 10);
                repeat (len)
                    add_value(plain_char(), dec);
            end
            else if (kind < 90)
            begin
                repeat ($urandom_range(1, 3))
                    add_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                add_byte(CH_PERCENT);
                repeat ($urandom_range(0, 2))
                begin
                    if ($urandom_range(0, 1))
                        add_byte(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
                    else
                        add_byte(8'($urandom_range(0, 255)));
                end
            end
        end
        add_end();
    endtask

    //------------------------------------------------------------------
    // Sequencing helpers
    //------------------------------------------------------------------

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_path.size() != 0 || path_valid || expected_out.size() != 0);
        // let a path that produced no result settle inside the block
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cfg(input logic idx, input bit [7:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic apply_settings(input bit [7:0] lim, input bit dec);
        wait_drained();
        write_cfg(CFG_MAX_PATH_BYTES, lim);
        write_cfg(CFG_PCT_DECODE, {7'd0, dec});
        lim_reg = lim;
        dec_en  = dec;
        settings_used++;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    //------------------------------------------------------------------
    // Path side: transfer detection and driver
    //------------------------------------------------------------------

    always @(posedge clk)
    begin
        path_xfer = rst_n && path_valid && path_ready;
        if (path_xfer)
            normalize_item(path_byte, path_end);
    end

    always @(negedge clk)
    begin : drive_path
        path_item_t nxt;
        if (rst_n && !(path_valid && !path_xfer))
        begin
            if (tx_gap != 0)
            begin
                tx_gap--;
                path_valid <= 1'b0;
            end
            else if (pending_path.size() != 0)
            begin
                nxt = pending_path.pop_front();
                path_valid <= 1'b1;
                path_byte  <= nxt.b;
                path_end   <= nxt.e;
                if (!quiet && $urandom_range(0, 11) == 0)
                    tx_gap = $urandom_range(1, 17);
            end
            else
                path_valid <= 1'b0;
        end
    end

    //------------------------------------------------------------------
    // Result side: ready pattern and checker
    //------------------------------------------------------------------

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rx_hold_req != 0)
            begin
                rx_stall    = rx_hold_req;
                rx_hold_req = 0;
            end
            if (rx_stall != 0)
            begin
                rx_stall--;
                res_ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 15) == 0)
            begin
                rx_stall = $urandom_range(1, 17) - 1;
                res_ready <= 1'b0;
            end
            else
                res_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_results
        norm_result_t got;
        norm_result_t want;
        if (rst_n && res_valid && res_ready)
        begin
            got = {out_byte, is_status, status, last};
            results_seen++;
            if (expected_out.size() == 0)
                report_mismatch("result with nothing expected", got.out_byte, 0);
            else
            begin
                want = expected_out.pop_front();
                if (got.out_byte !== want.out_byte)
                    report_mismatch("out_byte", got.out_byte, want.out_byte);
                if (got.is_status !== want.is_status)
                    report_mismatch("is_status", got.is_status, want.is_status);
                if (got.status !== want.status)
                    report_mismatch("status", got.status, want.status);
                if (got.last !== want.last)
                    report_mismatch("last", got.last, want.last);
            end
        end
    end

    // Watchdog: no transfer on either side for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((path_valid && path_ready) || (res_valid && res_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_CYCLES)
            begin
                $display("[%0t] watchdog: no transfer for %0d cycles", $time, idle_cycles);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    //------------------------------------------------------------------
    // Test sequence
    //------------------------------------------------------------------

    initial
    begin
        bit [7:0]    lim;
        bit          dec;
        int unsigned goal;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed, reset settings: separator with held dot, dot segment, escapes
        add_text("x/.y/./");
        add_end();
        add_text("%");          // path ends inside an escape
        add_end();
        add_text("%2F");        // decoded slash is forbidden
        add_end();
        add_text("%/");         // slash taken as a non-hex digit
        add_end();
        add_text("..");
        add_end();
        add_text("a ");         // trailing space
        add_end();
        add_end();              // nothing at all
        add_byte(8'hff);        // invalid UTF-8
        add_end();

        // Directed, one-byte limit and literal percent
        apply_settings(8'd1, 1'b0);
        add_text("ab");
        add_end();
        add_text("a/b");
        add_end();
        add_text("%");
        add_end();
        add_byte(8'h00);
        add_end();

        // Random phases over several settings
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0:       begin lim = 8'd255; dec = 1'b1; end
                1:       begin lim = 8'($urandom_range(4, 12)); dec = 1'b1; end
                2:       begin lim = 8'($urandom_range(2, 255)); dec = 1'b0; end
                3:       begin lim = 8'd3; dec = 1'b1; end
                default: begin lim = 8'd255; dec = 1'b1; end
            endcase
            apply_settings(lim, dec);
            // long receiver hold so the block backs up into its input
            if (phase == 0)
                rx_hold_req = 80;
            if (phase == 4)
                quiet = 1'b1;
            goal = items_queued + 46;
            while (items_queued < goal)
                add_random_path(lim, dec);
        end

        wait_drained();
        repeat (8) @(posedge clk);

        if (expected_out.size() != 0)
            report_mismatch("results never delivered", 0, expected_out.size());
        $display("Covered %0d paths in %0d input transfers under %0d register settings;",
                 paths_done, items_queued, settings_used);
        $display("%0d result transfers checked, %0d mismatches.", results_seen, error_count);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### url_path_normalizer.f
rtl/upn_pkg.sv
rtl/upn_step.sv
rtl/upn_res_fifo.sv
rtl/url_path_normalizer.sv
rtl/upn_checker.sv
test/tb_url_path_normalizer.sv
